[hdl/assert_macros.svh]
// Assertion macros shared by the locator RTL.
// Stand-alone header; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("%m: property violated");

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

[hdl/gel_pkg.sv]
// Shared types and constants for the GPT ESP locator.
// No dependencies; imported by every locator module.
`timescale 1ns / 1ps

package gel_pkg;

    localparam int MAX_ENTRIES = 128;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int POS_W = 9;   // byte index within header sector or entry
    localparam int IDX_W = 8;   // entry counter, wraps at 256

    localparam logic [POS_W-1:0] SECTOR_LAST   = 9'h1FF;
    localparam logic [POS_W-1:0] ENTRY_BYTES   = 9'h080;
    localparam logic [POS_W-1:0] ENTRY_LAST    = 9'h07F;
    localparam logic [POS_W-1:0] MAGIC_LEN     = 9'h008;
    localparam logic [POS_W-1:0] MAGIC_LAST    = 9'h007;
    localparam logic [POS_W-1:0] GUID_LEN      = 9'h010;
    localparam logic [POS_W-1:0] HDR_LBA_POS   = 9'h04F;
    localparam logic [POS_W-1:0] HDR_COUNT_POS = 9'h053;
    localparam logic [POS_W-1:0] HDR_SIZE_POS  = 9'h057;
    localparam logic [POS_W-1:0] ENT_LO_FIRST  = 9'h020;
    localparam logic [POS_W-1:0] ENT_LO_LAST   = 9'h027;
    localparam logic [POS_W-1:0] ENT_HI_FIRST  = 9'h028;
    localparam logic [POS_W-1:0] ENT_HI_LAST   = 9'h02B;
    localparam logic [POS_W-1:0] ENT_TOP_FIRST = 9'h02C;
    localparam logic [POS_W-1:0] ENT_TOP_LAST  = 9'h02F;

    localparam logic [63:0] TABLE_LBA       = 64'h0000_0000_0000_0002;
    localparam logic [31:0] ENTRY_SIZE_WORD = 32'h0000_0080;

    localparam logic [7:0] GPT_MAGIC [8] = '{
        8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
    };

    localparam logic [7:0] ESP_GUID [16] = '{
        8'h28, 8'h73, 8'h2a, 8'hc1, 8'h1f, 8'hf8, 8'hd2, 8'h11,
        8'hba, 8'h4b, 8'h00, 8'ha0, 8'hc9, 8'h3e, 8'hc9, 8'h3b
    };

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_BYTE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_ENTRIES = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    localparam logic [3:0] ST_BUSY       = 4'd0;
    localparam logic [3:0] ST_DONE_FOUND = 4'd1;
    localparam logic [3:0] ST_DONE_NONE  = 4'd2;
    localparam logic [3:0] ST_NOT_GPT    = 4'd3;
    localparam logic [3:0] ST_NOT_LBA2   = 4'd4;
    localparam logic [3:0] ST_TOO_MANY   = 4'd5;
    localparam logic [3:0] ST_BAD_SIZE   = 4'd6;
    localparam logic [3:0] ST_RANGE      = 4'd7;
    localparam logic [3:0] ST_INVALID    = 4'd8;
    localparam logic [3:0] ST_READ_OK    = 4'd9;
    localparam logic [3:0] ST_NO_PART    = 4'd10;
    localparam logic [3:0] ST_BEYOND     = 4'd11;

    typedef struct packed {
        op_t         op;
        logic [7:0]  image_byte;
        logic [31:0] sector_offset;
        logic [15:0] sector_count;
    } item_t;

endpackage

[hdl/gpt_esp_locator.sv]
// Top level of the GPT ESP locator: front decode, item queue, parser back end.
// Depends on gel_pkg, gel_front, gel_queue and gel_back.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser kind, s_tdata byte/offset/count
// m_       out  m_tvalid/m_tready  m_tuser status, m_tdata lba/count/start
//
// One item per cycle sustained while m_tready stays high; every item gives exactly one result.
// An item passes through the front register, a queue slot and the output register, in that order.
// The back end updates parser state for one item per cycle while its output register can take a result, in order.
// aresetn is synchronous; no clearing pass, the block is ready after reset.
// A stalled m_ side fills the output register, then the queue, then the front.
`timescale 1ns / 1ps

module gpt_esp_locator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // image_byte[7:0], sector_offset[39:8], sector_count[55:40]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // lba[31:0], read_count[47:32], partition_start[79:48]
    output logic [3:0]  m_tuser    // status[3:0]
);
    import gel_pkg::*;

    logic  f_valid;
    logic  f_ready;
    item_t f_item;
    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    gel_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    gel_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    gel_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[hdl/gel_front.sv]
// Front stage: takes input transfers, decodes the kind into an operation.
// Depends on gel_pkg.
`timescale 1ns / 1ps

module gel_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,   // image_byte[7:0], sector_offset[39:8], sector_count[55:40]
    input  logic [1:0]    s_tuser,   // kind[1:0]
    output logic          item_valid,
    input  logic          item_ready,
    output gel_pkg::item_t item
);
    import gel_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    op_t   op_dec;
    logic  take;

    always_comb begin
        unique case (kind_t'(s_tuser))
            KIND_START: op_dec = OP_START;
            KIND_BYTE:  op_dec = OP_BYTE;
            KIND_READ:  op_dec = OP_READ;
            default:    op_dec = OP_NOP;
        endcase
    end

    assign s_tready = !valid_reg || item_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        item_next = item_reg;
        if (take) begin
            item_next.op            = op_dec;
            item_next.image_byte    = s_tdata[7:0];
            item_next.sector_offset = s_tdata[39:8];
            item_next.sector_count  = s_tdata[55:40];
        end
        if (take) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/gel_queue.sv]
// Short FIFO of decoded items between the front and back stages.
// Depends on gel_pkg.
`timescale 1ns / 1ps

module gel_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  gel_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output gel_pkg::item_t out_item
);
    import gel_pkg::*;

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_CW-1:0]  count_reg;
    logic [QUEUE_CW-1:0]  count_next;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[hdl/gel_back.sv]
// Back stage: GPT header/entry parser, stored partition bounds, read checks
// and the result output register. Depends on gel_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gel_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           item_valid,
    output logic           item_ready,
    input  gel_pkg::item_t item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [79:0]    m_tdata,  // lba[31:0], read_count[47:32], partition_start[79:48]
    output logic [3:0]     m_tuser   // status[3:0]
);
    import gel_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [63:0]       shift_reg, shift_next;
    logic [IDX_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              tm_reg, tm_next;
    logic              sig_reg, sig_next;
    logic [31:0]       pstart_reg, pstart_next;
    logic [31:0]       pend_reg, pend_next;

    logic              ovalid_reg, ovalid_next;
    logic [3:0]        ostatus_reg;
    logic [31:0]       olba_reg;
    logic [15:0]       ocount_reg;
    logic [31:0]       opstart_reg;

    logic              pop;
    logic              fin;
    logic [3:0]        status;
    logic [31:0]       lba;
    logic [15:0]       rcount;
    logic [63:0]       sh_t;
    logic              sig_t;
    logic              tm_t;
    logic [IDX_W-1:0]  idx_t;
    logic [31:0]       sum;
    logic [3:0]        done_code;
    logic [7:0]        b;

    assign pop        = item_valid && (!ovalid_reg || m_tready);
    assign item_ready = !ovalid_reg || m_tready;
    assign b          = item.image_byte;
    assign sum        = pstart_reg + item.sector_offset;
    assign done_code  = (pstart_reg != '0) ? ST_DONE_FOUND : ST_DONE_NONE;

    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        tm_next     = tm_reg;
        sig_next    = sig_reg;
        pstart_next = pstart_reg;
        pend_next   = pend_reg;
        fin         = 1'b0;
        status      = ST_BUSY;
        lba         = '0;
        rcount      = '0;
        sh_t        = shift_reg;
        sig_t       = sig_reg;
        tm_t        = tm_reg;
        idx_t       = idx_reg;

        if (pop) begin
            unique case (item.op)
                OP_START: begin
                    phase_next = PH_HEADER;
                    pos_next   = '0;
                    shift_next = '0;
                    total_next = '0;
                    idx_next   = '0;
                    tm_next    = 1'b0;
                    sig_next   = 1'b1;
                end
                OP_BYTE: begin
                    if (phase_reg == PH_HEADER) begin
                        sh_t       = {b, shift_reg[63:8]};
                        shift_next = sh_t;
                        if (pos_reg < MAGIC_LEN) begin
                            sig_t    = sig_reg && (b == GPT_MAGIC[pos_reg[2:0]]);
                            sig_next = sig_t;
                            if (pos_reg == MAGIC_LAST && !sig_t) begin
                                fin    = 1'b1;
                                status = ST_NOT_GPT;
                            end
                        end
                        if (!fin && pos_reg == HDR_LBA_POS && sh_t != TABLE_LBA) begin
                            fin    = 1'b1;
                            status = ST_NOT_LBA2;
                        end
                        if (!fin && pos_reg == HDR_COUNT_POS) begin
                            if (sh_t[63:32] > 32'(MAX_ENTRIES)) begin
                                fin    = 1'b1;
                                status = ST_TOO_MANY;
                            end else begin
                                total_next = sh_t[32 +: IDX_W];
                            end
                        end
                        if (!fin && pos_reg == HDR_SIZE_POS
                                && sh_t[63:32] != ENTRY_SIZE_WORD) begin
                            fin    = 1'b1;
                            status = ST_BAD_SIZE;
                        end
                        if (!fin) begin
                            if (pos_reg == SECTOR_LAST) begin
                                if (total_reg == '0) begin
                                    fin    = 1'b1;
                                    status = done_code;
                                end else begin
                                    phase_next = PH_ENTRIES;
                                    pos_next   = '0;
                                    idx_next   = '0;
                                end
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                    end else if (phase_reg == PH_ENTRIES) begin
                        if (pos_reg < GUID_LEN) begin
                            tm_t    = ((pos_reg == '0) || tm_reg)
                                      && (b == ESP_GUID[pos_reg[3:0]]);
                            tm_next = tm_t;
                        end
                        // starting LBA: 8 bytes, upper half must be zero for a match
                        if (pos_reg >= ENT_LO_FIRST && pos_reg <= ENT_LO_LAST) begin
                            sh_t = {b, shift_reg[63:8]};
                            if (pos_reg == ENT_LO_LAST) begin
                                if (tm_t && sh_t[63:32] != '0) begin
                                    fin    = 1'b1;
                                    status = ST_RANGE;
                                end else begin
                                    sh_t[63:32] = '0;
                                end
                            end
                        end
                        // ending LBA low word lands in the upper half, byte by byte
                        if (pos_reg >= ENT_HI_FIRST && pos_reg <= ENT_HI_LAST) begin
                            sh_t = sh_t | ({56'd0, b} << {1'b1, pos_reg[1:0], 3'b000});
                        end
                        shift_next = sh_t;
                        if (!fin && pos_reg >= ENT_TOP_FIRST && pos_reg <= ENT_TOP_LAST
                                && tm_t && b != '0) begin
                            fin    = 1'b1;
                            status = ST_RANGE;
                        end
                        if (!fin && pos_reg == ENT_TOP_LAST && tm_t) begin
                            pstart_next = sh_t[31:0];
                            pend_next   = sh_t[63:32];
                            if (sh_t[63:32] < sh_t[31:0]) begin
                                fin    = 1'b1;
                                status = ST_INVALID;
                            end
                        end
                        if (!fin) begin
                            if (pos_reg == ENTRY_LAST) begin
                                pos_next = '0;
                                idx_t    = idx_reg + IDX_W'(1);
                                idx_next = idx_t;
                                if (idx_t >= total_reg) begin
                                    fin    = 1'b1;
                                    status = done_code;
                                end
                            end else begin
                                pos_next = pos_reg + POS_W'(1);
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (pstart_reg == '0) begin
                        status = ST_NO_PART;
                    end else if (sum > pend_reg) begin
                        status = ST_BEYOND;
                        lba    = sum;
                    end else begin
                        status = ST_READ_OK;
                        lba    = sum;
                        rcount = item.sector_count;
                    end
                end
                default: ;
            endcase
            if (fin) begin
                phase_next = PH_DONE;
            end
        end
    end

    always_comb begin
        if (pop) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            shift_reg  <= '0;
            total_reg  <= '0;
            idx_reg    <= '0;
            tm_reg     <= 1'b0;
            sig_reg    <= 1'b1;
            pstart_reg <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            tm_reg     <= tm_next;
            sig_reg    <= sig_next;
            pstart_reg <= pstart_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
        if (pop) begin
            ostatus_reg <= status;
            olba_reg    <= lba;
            ocount_reg  <= rcount;
            opstart_reg <= pstart_next;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostatus_reg;
    assign m_tdata  = {opstart_reg, ocount_reg, olba_reg};

    `ASSERT_PROP(a_entries_have_count, aclk, aresetn,
        (phase_reg == PH_ENTRIES) |->
            ((total_reg != '0) && (total_reg <= IDX_W'(MAX_ENTRIES))))
    `ASSERT_PROP(a_entry_pos_in_range, aclk, aresetn,
        (phase_reg == PH_ENTRIES) |-> (pos_reg < ENTRY_BYTES))
    `ASSERT_PROP(a_out_drains, aclk, aresetn,
        (ovalid_reg && m_tready && !pop) |=> !ovalid_reg)
    `ASSERT_NEVER(a_lba_only_on_reads, aclk, aresetn,
        ovalid_reg && (olba_reg != '0) && (ostatus_reg != ST_READ_OK)
            && (ostatus_reg != ST_BEYOND))
    `ASSERT_NEVER(a_count_only_on_ok, aclk, aresetn,
        ovalid_reg && (ocount_reg != '0) && (ostatus_reg != ST_READ_OK))

endmodule

[verif/esp_locate_checker.sv]
// Checker for the GPT ESP locator: watches both stream channels, predicts each result.
// Holds its own copy of the parser state; depends on gel_pkg for status codes and kinds.
`timescale 1ns / 1ps

module esp_locate_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // image_byte[7:0], sector_offset[39:8], sector_count[55:40]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,   // lba[31:0], read_count[47:32], partition_start[79:48]
    input  logic [3:0]  m_tuser,   // status[3:0]
    output int          fail_count,
    output int          outstanding
);
    import gel_pkg::*;

    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h45, 8'h46, 8'h49, 8'h20, 8'h50, 8'h41, 8'h52, 8'h54
    };
    localparam logic [7:0] ESP_TYPE_BYTES [16] = '{
        8'h28, 8'h73, 8'h2a, 8'hc1, 8'h1f, 8'hf8, 8'hd2, 8'h11,
        8'hba, 8'h4b, 8'h00, 8'ha0, 8'hc9, 8'h3e, 8'hc9, 8'h3b
    };

    // header field positions: last byte of each little-endian field
    localparam int POS_LBA_END   = 'h4F;
    localparam int POS_COUNT_END = 'h53;
    localparam int POS_SIZE_END  = 'h57;
    localparam int HEADER_LAST   = 511;
    localparam int ENTRY_LAST    = 127;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] lba;
        logic [15:0] read_count;
        logic [31:0] part_start;
    } esp_answer_t;

    esp_answer_t locate_answers[$];
    esp_answer_t want;
    int          results_seen = 0;

    phase_t      phase;
    logic [14:0] pos;
    logic [63:0] shift_acc;
    logic [7:0]  n_entries;
    logic [7:0]  entry_no;
    logic        guid_hit;
    logic        magic_ok;
    logic [31:0] stored_start;
    logic [31:0] esp_end;

    function automatic logic [3:0] close_scan(logic [3:0] code);
        phase = PH_DONE;
        return code;
    endfunction

    function automatic logic [3:0] scan_verdict();
        return close_scan(stored_start != 32'd0 ? ST_DONE_FOUND : ST_DONE_NONE);
    endfunction

    function automatic logic [3:0] header_step(logic [7:0] b);
        int p;
        p = int'(pos);
        shift_acc = {b, shift_acc[63:8]};
        if (p < 8) begin
            if (b != SIG_BYTES[p]) magic_ok = 1'b0;
            if (p == 7 && !magic_ok) return close_scan(ST_NOT_GPT);
        end
        if (p == POS_LBA_END && shift_acc != 64'd2) return close_scan(ST_NOT_LBA2);
        if (p == POS_COUNT_END) begin
            if (shift_acc[63:32] > 32'(MAX_ENTRIES)) return close_scan(ST_TOO_MANY);
            n_entries = shift_acc[39:32];
        end
        if (p == POS_SIZE_END && shift_acc[63:32] != 32'd128) return close_scan(ST_BAD_SIZE);
        if (p >= HEADER_LAST) begin
            if (n_entries == 8'd0) return scan_verdict();
            phase    = PH_ENTRIES;
            pos      = '0;
            entry_no = '0;
            return ST_BUSY;
        end
        pos = 15'(p + 1);
        return ST_BUSY;
    endfunction

    function automatic logic [3:0] entry_step(logic [7:0] b);
        int p;
        p = int'(pos);
        if (p < 16) begin
            if (p == 0) guid_hit = 1'b1;
            if (b != ESP_TYPE_BYTES[p]) guid_hit = 1'b0;
        end
        // start LBA, 64 bits; its upper half must be zero for the ESP
        if (p >= 'h20 && p <= 'h27) begin
            shift_acc = {b, shift_acc[63:8]};
            if (p == 'h27) begin
                if (guid_hit && shift_acc[63:32] != 32'd0) return close_scan(ST_RANGE);
                shift_acc[63:32] = 32'd0;
            end
        end
        if (p >= 'h28 && p <= 'h2B)
            shift_acc = shift_acc | (64'(b) << (32 + 8 * (p - 'h28)));
        if (p >= 'h2C && p <= 'h2F && guid_hit && b != 8'd0) return close_scan(ST_RANGE);
        if (p == 'h2F && guid_hit) begin
            stored_start = shift_acc[31:0];
            esp_end      = shift_acc[63:32];
            if (esp_end < stored_start) return close_scan(ST_INVALID);
        end
        if (p >= ENTRY_LAST) begin
            pos      = '0;
            entry_no = entry_no + 8'd1;
            if (entry_no >= n_entries) return scan_verdict();
            return ST_BUSY;
        end
        pos = 15'(p + 1);
        return ST_BUSY;
    endfunction

    function automatic esp_answer_t locate_step(kind_t k, logic [7:0] b, logic [31:0] off,
                                                logic [15:0] cnt);
        esp_answer_t a;
        a = '0;
        case (k)
            KIND_START: begin
                pos       = '0;
                phase     = PH_HEADER;
                shift_acc = '0;
                n_entries = '0;
                entry_no  = '0;
                guid_hit  = 1'b0;
                magic_ok  = 1'b1;
            end
            KIND_BYTE: begin
                if (phase == PH_HEADER) a.status = header_step(b);
                else if (phase == PH_ENTRIES) a.status = entry_step(b);
            end
            KIND_READ: begin
                if (stored_start == 32'd0) begin
                    a.status = ST_NO_PART;
                end else begin
                    a.lba = stored_start + off;
                    if (a.lba > esp_end) begin
                        a.status = ST_BEYOND;
                    end else begin
                        a.status     = ST_READ_OK;
                        a.read_count = cnt;
                    end
                end
            end
            default: ;
        endcase
        a.part_start = stored_start;
        return a;
    endfunction

    task automatic report_diff(string field, logic [31:0] got, logic [31:0] exp_val);
        $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h",
                 $time, results_seen, field, got, exp_val);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase        = PH_IDLE;
            pos          = '0;
            shift_acc    = '0;
            n_entries    = '0;
            entry_no     = '0;
            guid_hit     = 1'b0;
            magic_ok     = 1'b1;
            stored_start = '0;
            esp_end      = '0;
            fail_count   = 0;
            locate_answers.delete();
            outstanding <= 0;
        end else begin
            if (s_tvalid && s_tready)
                locate_answers.push_back(locate_step(kind_t'(s_tuser), s_tdata[7:0],
                                                     s_tdata[39:8], s_tdata[55:40]));
            if (m_tvalid && m_tready) begin
                if (locate_answers.size() == 0) begin
                    report_diff("status, no item pending", 32'(m_tuser), 32'd0);
                end else begin
                    want = locate_answers.pop_front();
                    if (m_tuser !== want.status)
                        report_diff("status", 32'(m_tuser), 32'(want.status));
                    if (m_tdata[31:0] !== want.lba)
                        report_diff("lba", m_tdata[31:0], want.lba);
                    if (m_tdata[47:32] !== want.read_count)
                        report_diff("read_count", 32'(m_tdata[47:32]), 32'(want.read_count));
                    if (m_tdata[79:48] !== want.part_start)
                        report_diff("partition_start", m_tdata[79:48], want.part_start);
                end
                results_seen++;
            end
            outstanding <= locate_answers.size();
        end
    end

endmodule

[verif/tb_gpt_esp_locator.sv]
// Testbench top for the GPT ESP locator: clock, reset, stimulus and verdict.
// Streams GPT images, reads and noise into uut; esp_locate_checker does the comparing.
`timescale 1ns / 1ps

module tb_gpt_esp_locator;
    import gel_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int ITEM_GOAL   = 750;
    localparam int NO_CUT      = 32'h7FFF_FFFF;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [55:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = KIND_NOP;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [79:0] m_tdata;
    logic [3:0]  m_tuser;

    int          fail_count;
    int          outstanding;
    int          items_sent = 0;
    int          quiet      = 0;
    bit          calm       = 1'b0;
    logic [31:0] start_hint = '0;
    logic [31:0] span_hint  = '0;

    always #5 aclk = ~aclk;

    gpt_esp_locator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    esp_locate_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // ends the run when neither channel has moved a transfer for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("gpt_esp_locator: mismatch");
                $finish;
            end
        end
    end

    task automatic put_item(kind_t k, logic [7:0] b, logic [31:0] off, logic [15:0] cnt);
        while (!calm && $urandom_range(0, 99) < 30) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {cnt, off, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic put_read();
        logic [31:0] off;
        case ($urandom_range(0, 4))
            0:       off = $urandom();
            1:       off = $urandom_range(0, 3);
            2:       off = span_hint + $urandom_range(0, 2) - 1;
            3:       off = 32'd0 - start_hint + $urandom_range(0, 3);   // wraps past 2^32
            default: off = $urandom_range(0, span_hint);
        endcase
        put_item(KIND_READ, 8'($urandom()), off, 16'($urandom()));
    endtask

    // image byte, now and then preceded by a read or an idle item mid-scan
    task automatic feed(logic [7:0] b);
        if ($urandom_range(0, 99) < 3) put_read();
        else if ($urandom_range(0, 99) < 2)
            put_item(KIND_NOP, 8'($urandom()), $urandom(), 16'($urandom()));
        put_item(KIND_BYTE, b, $urandom(), 16'($urandom()));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic run_scan();
        logic [63:0] lba_f;
        logic [31:0] cnt_f;
        logic [31:0] size_f;
        logic [63:0] s64;
        logic [63:0] e64;
        logic [7:0]  b;
        logic [7:0]  ent [128];
        int          bad_magic;
        int          last;
        int          cut;
        int          sent;
        int          sel;
        bit          is_esp;
        bit          stops;

        put_item(KIND_START, 8'($urandom()), $urandom(), 16'($urandom()));
        lba_f     = 64'd2;
        size_f    = 32'd128;
        cnt_f     = $urandom_range(0, 3);
        bad_magic = -1;
        last      = 511;
        cut       = NO_CUT;
        sent      = 0;
        case ($urandom_range(0, 19))
            0, 1: begin
                bad_magic = $urandom_range(0, 7);
                last = 7;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0:       lba_f = 64'd3;
                    1:       lba_f = 64'h1_0000_0002;
                    2:       lba_f = {$urandom(), $urandom()};
                    default: lba_f = 64'd2 ^ (64'd1 << $urandom_range(0, 63));
                endcase
                last = 'h4F;
            end
            3: begin
                case ($urandom_range(0, 2))
                    0:       cnt_f = 32'd129;
                    1:       cnt_f = 32'hFFFF_FFFF;
                    default: cnt_f = $urandom_range(129, 32'hFFFF_FFFF);
                endcase
                last = 'h53;
            end
            4: begin
                case ($urandom_range(0, 4))
                    0:       size_f = 32'd0;
                    1:       size_f = 32'd127;
                    2:       size_f = 32'd129;
                    3:       size_f = 32'h8000_0080;
                    default: size_f = $urandom();
                endcase
                last = 'h57;
            end
            default: begin
                case ($urandom_range(0, 19))
                    0, 1, 2: cnt_f = 32'd0;
                    3: begin
                        cnt_f = MAX_ENTRIES;
                        cut = 512 + 256 + $urandom_range(0, 127);
                    end
                    4, 5:    cnt_f = $urandom_range(4, 6);
                    default: cnt_f = $urandom_range(1, 3);
                endcase
            end
        endcase
        // header errors: a few trailing bytes that the block must ignore
        if (last != 511) last = last + $urandom_range(0, 3);
        if (cut == NO_CUT && $urandom_range(0, 6) == 0) cut = $urandom_range(0, 700);

        for (int p = 0; p <= last; p++) begin
            if (sent == cut) return;
            if (p < 8)
                b = GPT_MAGIC[p] ^ (p == bad_magic ? 8'(1 << $urandom_range(0, 7)) : 8'h00);
            else if (p >= 'h48 && p < 'h50) b = lba_f[8 * (p - 'h48) +: 8];
            else if (p >= 'h50 && p < 'h54) b = cnt_f[8 * (p - 'h50) +: 8];
            else if (p >= 'h54 && p < 'h58) b = size_f[8 * (p - 'h54) +: 8];
            else b = 8'($urandom());
            feed(b);
            sent++;
        end
        if (last != 511) return;

        for (int e = 0; e < int'(cnt_f); e++) begin
            for (int i = 0; i < 128; i++) ent[i] = 8'($urandom());
            sel    = $urandom_range(0, 5);
            is_esp = (sel <= 2);
            stops  = 1'b0;
            if (sel <= 3) begin
                for (int i = 0; i < 16; i++) ent[i] = ESP_GUID[i];
                // near miss: one bit off in the type GUID
                if (sel == 3) begin
                    sel = $urandom_range(0, 15);
                    ent[sel] = ent[sel] ^ 8'(1 << $urandom_range(0, 7));
                end
            end
            if (is_esp) begin
                case ($urandom_range(0, 9))
                    0: begin
                        s64 = 64'd0;
                        e64 = 64'($urandom());
                    end
                    1: begin
                        s64 = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom())};
                        e64 = 64'($urandom());
                        stops = 1'b1;
                    end
                    2: begin
                        s64 = 64'($urandom_range(1, 1000));
                        e64 = {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom())};
                        stops = 1'b1;
                    end
                    3: begin
                        // end below start: stored, then reported invalid
                        s64 = 64'($urandom_range(2, 32'h7FFF_FFFF));
                        e64 = s64 - 64'($urandom_range(1, s64[31:0]));
                        stops = 1'b1;
                        start_hint = s64[31:0];
                        span_hint  = e64[31:0] - s64[31:0];
                    end
                    4: begin
                        s64 = 64'h0000_0000_FFFF_FFFF;
                        e64 = 64'h0000_0000_FFFF_FFFF;
                    end
                    default: begin
                        s64 = 64'($urandom_range(1, 32'h00FF_FFFF));
                        e64 = s64 + 64'($urandom_range(0, 5000));
                    end
                endcase
                if (!stops) begin
                    start_hint = s64[31:0];
                    span_hint  = e64[31:0] - s64[31:0];
                end
                for (int k = 0; k < 8; k++) begin
                    ent['h20 + k] = s64[8 * k +: 8];
                    ent['h28 + k] = e64[8 * k +: 8];
                end
            end
            for (int i = 0; i < 128; i++) begin
                if (sent == cut) return;
                feed(ent[i]);
                sent++;
            end
            if (stops) return;
        end
    endtask

    initial begin
        int n;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        calm = 1'b1;

        // nothing stored yet: reads answer no partition
        put_item(KIND_READ, 8'h00, 32'h0000_0000, 16'hFFFF);
        put_item(KIND_READ, 8'hFF, 32'hFFFF_FFFF, 16'h0000);
        put_item(KIND_NOP, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_item(KIND_NOP, 8'h00, 32'h0000_0000, 16'h0000);
        // bytes outside a scan are ignored
        put_item(KIND_BYTE, 8'hFF, 32'h0, 16'h0);
        put_item(KIND_BYTE, 8'h00, 32'hFFFF_FFFF, 16'hFFFF);
        put_item(KIND_START, 8'h00, 32'h0, 16'h0);
        // signature with the last byte wrong: not GPT at the eighth byte
        for (int i = 0; i < 8; i++)
            put_item(KIND_BYTE, i == 7 ? 8'h55 : GPT_MAGIC[i], 32'h0, 16'h0);
        put_item(KIND_BYTE, 8'h45, 32'h0, 16'h0);
        // restart from the done phase, then an immediate read during the scan
        put_item(KIND_START, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        put_item(KIND_READ, 8'h00, 32'h0000_0001, 16'h0001);
        put_item(KIND_START, 8'h00, 32'h0, 16'h0);
        drain();
        calm = 1'b0;

        n = 0;
        while (items_sent < ITEM_GOAL) begin
            calm = (n == 1);
            if ($urandom_range(0, 9) == 0) drain();
            if ($urandom_range(0, 9) < 7) begin
                run_scan();
            end else begin
                repeat ($urandom_range(3, 12)) begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: put_read();
                        3, 4:    put_item(KIND_NOP, 8'($urandom()), $urandom(),
                                          16'($urandom()));
                        5, 6:    put_item(KIND_BYTE, 8'($urandom()), $urandom(),
                                          16'($urandom()));
                        default: put_item(KIND_START, 8'($urandom()), $urandom(),
                                          16'($urandom()));
                    endcase
                end
            end
            n++;
        end

        drain();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) $display("gpt_esp_locator: match");
        else $display("gpt_esp_locator: mismatch");
        $finish;
    end

endmodule
